@@ rtl/periodic_task_scheduler_defines.svh @@
// ----------------------------------------------------------------------------
// Periodic task scheduler assertion macros
// Concurrent property wrappers clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define PTS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define PTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Command codes, result codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_SYNC   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_FLUSH
   } state_type;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FIRE   = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   localparam logic [15:0] MIN_PERIOD = 16'd1;

   typedef struct packed {
      logic        kind;
      logic        status;
      logic [3:0]  slot;
      logic [15:0] fired_key;
      logic [31:0] fire_time;
      logic [4:0]  active_count;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/periodic_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// Periodic task scheduler: every request except a tick with an unchanged time sweeps all
// MAX_TASKS slots, one per cycle while a fire is not stalled by a busy result output.
// A tick with an unchanged time retires without a sweep; no new request is taken until idle.
// Synchronous reset empties the table and zeroes the tick time at once.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_scheduler
   import pts_pkg::*;
#(
   parameter int MAX_TASKS = 16,
   parameter int KEY_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_task_key,
   input  wire logic [15:0] req_interval,
   input  wire logic [31:0] req_now,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic             rsp_status,
   output logic [3:0]       rsp_slot,
   output logic [15:0]      rsp_fired_key,
   output logic [31:0]      rsp_fire_time,
   output logic [4:0]       rsp_active_count,
   output logic             rsp_last
);

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int KW = (KEY_WIDTH < 16) ? KEY_WIDTH : 16;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

   logic [KW-1:0] key_mem [MAX_TASKS];
   logic [15:0]   per_mem [MAX_TASKS];
   logic [31:0]   run_mem [MAX_TASKS];

   state_type            state_ff, state_in;
   cmd_type              op_ff, op_in;
   logic [KW-1:0]        key_ff, key_in;
   logic [15:0]          ival_ff, ival_in;
   logic [31:0]          now_ff, now_in;
   logic [31:0]          prev_tick_ff, prev_tick_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [MAX_TASKS-1:0] valid_ff, valid_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic                 issue_ff, issue_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 found_ff, found_in;
   logic                 free_vld_ff, free_vld_in;
   logic [IW-1:0]        free_idx_ff, free_idx_in;
   logic [IW-1:0]        hit_idx_ff, hit_idx_in;
   rsp_type              pend_ff, pend_in;
   logic                 pend_vld_ff, pend_vld_in;
   rsp_type              out_ff, out_in;
   logic                 out_vld_ff, out_vld_in;

   logic [KW-1:0] key_rd_ff;
   logic [15:0]   per_rd_ff;
   logic [31:0]   run_rd_ff;

   logic          rd_en;
   logic          tbl_we;
   logic [IW-1:0] tbl_wa;
   logic [KW-1:0] key_wd;
   logic [15:0]   per_wd;
   logic          run_we;
   logic [IW-1:0] run_wa;
   logic [31:0]   run_wd;

   logic          out_free;
   logic          key_hit;
   logic          due;
   logic          fire;
   logic          stall;
   logic [31:0]   elapsed;
   rsp_type       fail_rsp;

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !out_vld_ff || rsp_ready;
   assign key_hit   = valid_ff[rd_idx_ff] && (key_rd_ff == key_ff);
   assign elapsed   = now_ff - run_rd_ff;
   assign due       = valid_ff[rd_idx_ff] && !elapsed[31] && (elapsed >= {16'd0, per_rd_ff});
   assign fire      = (state_ff == S_SCAN) && (op_ff == CMD_TICK) && rd_vld_ff && due;
   assign stall     = fire && pend_vld_ff && !out_free;

   assign fail_rsp = '{kind: KIND_STATUS, status: STATUS_FAIL, slot: 4'd0,
                       fired_key: 16'(key_ff), fire_time: 32'd0,
                       active_count: 5'(count_ff), last: 1'b1};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      ival_in      = ival_ff;
      now_in       = now_ff;
      prev_tick_in = prev_tick_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      rd_vld_in    = rd_vld_ff;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      hit_idx_in   = hit_idx_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      out_in       = out_ff;
      out_vld_in   = out_vld_ff && !rsp_ready;
      rd_en        = 1'b0;
      tbl_we       = 1'b0;
      tbl_wa       = free_idx_ff;
      key_wd       = key_ff;
      per_wd       = (ival_ff == 16'd0) ? MIN_PERIOD : ival_ff;
      run_we       = 1'b0;
      run_wa       = rd_idx_ff;
      run_wd       = now_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = cmd_type'(req_command);
               key_in      = req_task_key[KW-1:0];
               ival_in     = req_interval;
               now_in      = req_now;
               found_in    = 1'b0;
               free_vld_in = 1'b0;
               idx_in      = '0;
               issue_in    = 1'b1;
               rd_vld_in   = 1'b0;
               if (req_command == CMD_TICK) begin
                  if (req_now != prev_tick_ff) begin
                     prev_tick_in = req_now;
                     state_in     = S_SCAN;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (!stall) begin
               if (issue_ff) begin
                  rd_en     = 1'b1;
                  rd_vld_in = 1'b1;
                  rd_idx_in = idx_ff;
                  idx_in    = idx_ff + 1'b1;
                  if (idx_ff == LAST_IDX) begin
                     issue_in = 1'b0;
                  end
               end else begin
                  rd_vld_in = 1'b0;
               end
               if (rd_vld_ff) begin
                  unique case (op_ff)
                     CMD_TICK: begin
                        if (due) begin
                           if (pend_vld_ff) begin
                              out_in     = pend_ff;
                              out_vld_in = 1'b1;
                           end
                           run_we      = 1'b1;
                           pend_in     = '{kind: KIND_FIRE, status: STATUS_OK,
                                           slot: 4'(rd_idx_ff),
                                           fired_key: 16'(key_rd_ff),
                                           fire_time: now_ff,
                                           active_count: 5'(count_ff),
                                           last: 1'b0};
                           pend_vld_in = 1'b1;
                        end
                     end
                     CMD_ADD: begin
                        if (key_hit) begin
                           found_in = 1'b1;
                        end
                        if (!valid_ff[rd_idx_ff] && !free_vld_ff) begin
                           free_vld_in = 1'b1;
                           free_idx_in = rd_idx_ff;
                        end
                     end
                     CMD_REMOVE: begin
                        if (key_hit) begin
                           found_in   = 1'b1;
                           hit_idx_in = rd_idx_ff;
                        end
                     end
                     CMD_SYNC: begin
                        run_we = 1'b1;
                     end
                  endcase
               end
               if (!issue_ff && !rd_vld_ff) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            state_in    = S_FLUSH;
            pend_vld_in = 1'b1;
            unique case (op_ff)
               CMD_TICK: begin
                  pend_vld_in = pend_vld_ff;
                  if (pend_vld_ff) begin
                     pend_in.last = 1'b1;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               CMD_ADD: begin
                  if ((key_ff == '0) || found_ff || !free_vld_ff) begin
                     pend_in = fail_rsp;
                  end else begin
                     tbl_we                = 1'b1;
                     run_we                = 1'b1;
                     run_wa                = free_idx_ff;
                     run_wd                = 32'd0;
                     valid_in[free_idx_ff] = 1'b1;
                     count_in              = count_ff + 1'b1;
                     pend_in               = '{kind: KIND_STATUS, status: STATUS_OK,
                                               slot: 4'(free_idx_ff),
                                               fired_key: 16'(key_ff),
                                               fire_time: 32'd0,
                                               active_count: 5'(count_in),
                                               last: 1'b1};
                  end
               end
               CMD_REMOVE: begin
                  if (found_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     count_in             = count_ff - 1'b1;
                     pend_in              = '{kind: KIND_STATUS, status: STATUS_OK,
                                              slot: 4'(hit_idx_ff),
                                              fired_key: 16'(key_ff),
                                              fire_time: 32'd0,
                                              active_count: 5'(count_in),
                                              last: 1'b1};
                  end else begin
                     pend_in = fail_rsp;
                  end
               end
               CMD_SYNC: begin
                  pend_in = '{kind: KIND_STATUS, status: STATUS_OK, slot: 4'd0,
                              fired_key: 16'd0, fire_time: 32'd0,
                              active_count: 5'(count_ff), last: 1'b1};
               end
            endcase
         end
         S_FLUSH: begin
            if (out_free) begin
               out_in      = pend_ff;
               out_vld_in  = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_tick_ff <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         free_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_tick_ff <= prev_tick_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         free_vld_ff  <= free_vld_in;
         pend_vld_ff  <= pend_vld_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      ival_ff     <= ival_in;
      now_ff      <= now_in;
      idx_ff      <= idx_in;
      rd_idx_ff   <= rd_idx_in;
      free_idx_ff <= free_idx_in;
      hit_idx_ff  <= hit_idx_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         key_mem[tbl_wa] <= key_wd;
         per_mem[tbl_wa] <= per_wd;
      end
      if (run_we) begin
         run_mem[run_wa] <= run_wd;
      end
      if (rd_en) begin
         key_rd_ff <= key_mem[idx_ff];
         per_rd_ff <= per_mem[idx_ff];
         run_rd_ff <= run_mem[idx_ff];
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_status       = out_ff.status;
   assign rsp_slot         = out_ff.slot;
   assign rsp_fired_key    = out_ff.fired_key;
   assign rsp_fire_time    = out_ff.fire_time;
   assign rsp_active_count = out_ff.active_count;
   assign rsp_last         = out_ff.last;

endmodule

`default_nettype wire

@@ rtl/pts_checker.sv @@
// ----------------------------------------------------------------------------
// Periodic task scheduler port checker
// Watches the request and result ports and flags inconsistent results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_scheduler_defines.svh"

module pts_checker
   import pts_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_command,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_kind,
   input wire logic        rsp_status,
   input wire logic [31:0] rsp_fire_time,
   input wire logic [4:0]  rsp_active_count,
   input wire logic        rsp_last
);

   `PTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `PTS_ASSERT_IMPL(a_fire_ok, rsp_valid && rsp_kind == KIND_FIRE, rsp_status == STATUS_OK)
   `PTS_ASSERT_IMPL(a_status_last, rsp_valid && rsp_kind == KIND_STATUS, rsp_last && rsp_fire_time == 32'd0)
   `PTS_ASSERT_NEXT(a_busy_after_cmd, req_valid && req_ready && req_command != CMD_TICK, !req_ready)
   `PTS_ASSERT_IMPL(a_count_range, rsp_valid, int'(rsp_active_count) <= MAX_TASKS)

endmodule

bind periodic_task_scheduler pts_checker #(
   .MAX_TASKS(MAX_TASKS)
) u_pts_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_command      (req_command),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_status       (rsp_status),
   .rsp_fire_time    (rsp_fire_time),
   .rsp_active_count (rsp_active_count),
   .rsp_last         (rsp_last)
);

`default_nettype wire
